/* hdl/apcg_pkg.sv */
package apcg_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned INDEX_BITS_DEF      = 12;

  // Input and configuration field widths
  localparam int unsigned PIXEL_W  = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned SINE_W   = 15;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_SPEED  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH     = 8'd3;

  localparam logic [LEN_W-1:0] STRIP_LENGTH_RST = 13'd60;
  localparam logic [15:0]      DRIFT_SPEED_RST  = 16'd256;
  localparam logic [15:0]      HUE_LOW_RST      = 16'd19661;
  localparam logic [15:0]      HUE_HIGH_RST     = 16'd55706;

  // Phase increments in Q0.32 turns per unit
  localparam logic [31:0] K_X1   = 32'd3486182905;
  localparam logic [31:0] K_X2   = 32'd1572200134;
  localparam logic [31:0] K_X3   = 32'd2529191520;
  localparam logic [31:0] K_T1   = 32'd211905235;
  localparam logic [31:0] K_T2   = 32'd116206097;
  localparam logic [31:0] K_T3   = 32'd157220013;
  localparam logic [31:0] K_OFF3 = 32'd1162060968;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam int unsigned V_BASE = 36045;
  localparam int unsigned V_AMP2 = 58982;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [PHASE_W-1:0] p1;
    logic [PHASE_W-1:0] p2;
    logic [PHASE_W-1:0] p3;
  } phase_t;

  // Quarter-wave sine entry in unsigned Q0.15, Taylor series in Q2.30
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned k, int unsigned bits);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint          sum;
    longint unsigned e;
    th   = (longint'(k) * longint'(HALF_PI_Q30) + (64'd1 << (bits - 1))) >> bits;
    th2  = (th * th) >> 30;
    term = th;
    sum  = longint'(th);
    term = ((term * th2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * th2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * th2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * th2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * th2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * th2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * th2) >> 30) / 210; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    e = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
    if (e > 32767) e = 32767;
    return SINE_W'(e);
  endfunction

endpackage

/* hdl/apcg_front.sv */
module apcg_front #(
  parameter int unsigned INDEX_BITS = apcg_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic [INDEX_BITS-1:0]        pixel_index_i,
  input  logic [apcg_pkg::TIME_W-1:0]  frame_time_i,
  input  logic [apcg_pkg::LEN_W-1:0]   divisor_i,
  input  logic [15:0]                  drift_speed_i,
  output logic                         out_valid_o,
  output apcg_pkg::phase_t             phase_o
);

  localparam int unsigned QW = INDEX_BITS + 16;
  localparam int unsigned LW = apcg_pkg::LEN_W;

  // Divider pipeline: one quotient bit per stage
  logic [QW:0]                       dv_q;
  logic [LW-1:0]                     rem_q [0:QW];
  logic [QW-1:0]                     quo_q [0:QW];
  logic [apcg_pkg::TIME_W-1:0]       tt_q  [0:QW];
  logic [LW-1:0]                     rem_d [0:QW-1];
  logic [QW-1:0]                     quo_d [0:QW-1];
  logic [LW:0]                       trial [0:QW-1];
  logic                              ge    [0:QW-1];

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial[s] = {rem_q[s], quo_q[s][QW-1]};
      ge[s]    = trial[s] >= {1'b0, divisor_i};
      rem_d[s] = ge[s] ? LW'(trial[s] - {1'b0, divisor_i}) : LW'(trial[s]);
      quo_d[s] = {quo_q[s][QW-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en_i) begin
      dv_q <= {dv_q[QW-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= {pixel_index_i, 16'd0};
      tt_q[0]  <= frame_time_i;
      for (int s = 0; s < QW; s++) begin
        rem_q[s+1] <= rem_d[s];
        quo_q[s+1] <= quo_d[s];
        tt_q[s+1]  <= tt_q[s];
      end
    end
  end

  // Position, scaled time, products, phase sums
  logic [2:0]          mv_q;
  logic [QW-1:0]       x_q;
  logic [47:0]         ts_q;
  logic [31:0]         px1_q, px2_q, px3_q;
  logic [55:0]         tl1_q, tl2_q, tl3_q;
  logic [25:0]         th1_q, th2_q, th3_q;
  apcg_pkg::phase_t    ph_q;
  logic [63:0]         pp1, pp2, pp3;
  logic [55:0]         hh1, hh2, hh3;
  logic [49:0]         ts1, ts2, ts3;

  always_comb begin
    pp1 = 64'(x_q) * 64'(apcg_pkg::K_X1);
    pp2 = 64'(x_q) * 64'(apcg_pkg::K_X2);
    pp3 = 64'(x_q) * 64'(apcg_pkg::K_X3);
    hh1 = 56'(ts_q[47:24]) * 56'(apcg_pkg::K_T1);
    hh2 = 56'(ts_q[47:24]) * 56'(apcg_pkg::K_T2);
    hh3 = 56'(ts_q[47:24]) * 56'(apcg_pkg::K_T3);
    ts1 = tl1_q[49:0] + {th1_q, 24'd0};
    ts2 = tl2_q[49:0] + {th2_q, 24'd0};
    ts3 = tl3_q[49:0] + {th3_q, 24'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= '0;
    end else if (en_i) begin
      mv_q <= {mv_q[1:0], dv_q[QW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= quo_q[QW];
      ts_q  <= {16'd0, tt_q[QW]} * {32'd0, drift_speed_i};
      px1_q <= pp1[47:16];
      px2_q <= pp2[47:16];
      px3_q <= pp3[47:16];
      tl1_q <= 56'(ts_q[23:0]) * 56'(apcg_pkg::K_T1);
      tl2_q <= 56'(ts_q[23:0]) * 56'(apcg_pkg::K_T2);
      tl3_q <= 56'(ts_q[23:0]) * 56'(apcg_pkg::K_T3);
      th1_q <= hh1[25:0];
      th2_q <= hh2[25:0];
      th3_q <= hh3[25:0];
      ph_q.p1 <= px1_q + ts1[49:18];
      ph_q.p2 <= px2_q - ts2[49:18];
      ph_q.p3 <= px3_q + ts3[49:18] + apcg_pkg::K_OFF3;
    end
  end

  assign out_valid_o = mv_q[2];
  assign phase_o     = ph_q;

endmodule

/* hdl/apcg_fifo.sv */
module apcg_fifo #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = apcg_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o  = cnt_q == (PW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* hdl/apcg_sine_rom.sv */
module apcg_sine_rom #(
  parameter int unsigned TABLE_BITS = apcg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [TABLE_BITS:0]         addr_i,
  output logic [apcg_pkg::SINE_W-1:0] data_o
);

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  logic [apcg_pkg::SINE_W-1:0] rom_w [0:DEPTH-1];
  logic [apcg_pkg::SINE_W-1:0] data_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    assign rom_w[k] = apcg_pkg::sine_entry(k, TABLE_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

/* hdl/apcg_back.sv */
module apcg_back #(
  parameter int unsigned SINE_TABLE_BITS = apcg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_avail_i,
  input  apcg_pkg::phase_t phase_i,
  output logic             pop_o,
  input  logic [15:0]      hue_low_i,
  input  logic [15:0]      hue_high_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o
);

  localparam int unsigned B  = SINE_TABLE_BITS;
  localparam int unsigned SW = apcg_pkg::SINE_W;

  logic        en;
  logic [5:0]  v_q;
  logic [2:0]  neg_q;
  logic [SW-1:0] mag1, mag2, mag3;

  assign en    = !v_q[5] || out_ready_i;
  assign pop_o = en && in_avail_i;

  function automatic logic [B:0] rom_addr(logic [31:0] ph);
    logic [B-1:0] idx;
    idx = ph[29 -: B];
    return ph[30] ? (B+1)'(1 << B) - {1'b0, idx} : {1'b0, idx};
  endfunction

  apcg_sine_rom #(.TABLE_BITS(B)) u_rom1 (
    .clk_i(clk_i), .en_i(en), .addr_i(rom_addr(phase_i.p1)), .data_o(mag1));
  apcg_sine_rom #(.TABLE_BITS(B)) u_rom2 (
    .clk_i(clk_i), .en_i(en), .addr_i(rom_addr(phase_i.p2)), .data_o(mag2));
  apcg_sine_rom #(.TABLE_BITS(B)) u_rom3 (
    .clk_i(clk_i), .en_i(en), .addr_i(rom_addr(phase_i.p3)), .data_o(mag3));

  // Signed sines, weight, brightness, hue sector and colour channels
  logic signed [16:0] s1, s2, s3;
  logic signed [17:0] wsum;
  logic signed [32:0] vsum;
  logic [15:0] w_q, vb_q, vc_q, vd_q, ve_q;
  logic [31:0] plo_q, phi_q;
  logic [32:0] hsum;
  logic [18:0] h6;
  logic [2:0]  sec_d_q, sec_e_q;
  logic [15:0] f_q;
  logic [16:0] mf;
  logic [32:0] sp;
  logic [15:0] secv_q;
  logic [23:0] cs, ss;
  logic [7:0]  c8, s8;
  logic [7:0]  r_q, g_q, b_q;

  always_comb begin
    s1   = neg_q[0] ? -$signed({2'b00, mag1}) : $signed({2'b00, mag1});
    s2   = neg_q[1] ? -$signed({2'b00, mag2}) : $signed({2'b00, mag2});
    s3   = neg_q[2] ? -$signed({2'b00, mag3}) : $signed({2'b00, mag3});
    wsum = 18'sd65536 + 18'(s1) + 18'(s2);
    vsum = $signed(33'(apcg_pkg::V_BASE * 65536)) + $signed(33'(apcg_pkg::V_AMP2)) * 33'(s3);
    hsum = {1'b0, plo_q} + {1'b0, phi_q};
    h6   = {1'b0, hsum[31:16], 2'b00} + {2'b00, hsum[31:16], 1'b0};
    mf   = sec_d_q[0] ? 17'd65536 - {1'b0, f_q} : {1'b0, f_q};
    sp   = 33'(vd_q) * 33'(mf);
    cs   = {ve_q, 8'd0} - {8'd0, ve_q};
    ss   = {secv_q, 8'd0} - {8'd0, secv_q};
    c8   = cs[23:16];
    s8   = ss[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q   <= {phase_i.p3[31], phase_i.p2[31], phase_i.p1[31]};
      w_q     <= wsum[16:1];
      vb_q    <= vsum[31:16];
      plo_q   <= 32'({16'd0, hue_low_i} * (32'd65536 - {16'd0, w_q}));
      phi_q   <= {16'd0, hue_high_i} * {16'd0, w_q};
      vc_q    <= vb_q;
      sec_d_q <= h6[18:16];
      f_q     <= h6[15:0];
      vd_q    <= vc_q;
      secv_q  <= sp[31:16];
      sec_e_q <= sec_d_q;
      ve_q    <= vd_q;
      unique case (sec_e_q)
        3'd0:    begin r_q <= c8;   g_q <= s8;   b_q <= 8'd0; end
        3'd1:    begin r_q <= s8;   g_q <= c8;   b_q <= 8'd0; end
        3'd2:    begin r_q <= 8'd0; g_q <= c8;   b_q <= s8;   end
        3'd3:    begin r_q <= 8'd0; g_q <= s8;   b_q <= c8;   end
        3'd4:    begin r_q <= s8;   g_q <= 8'd0; b_q <= c8;   end
        default: begin r_q <= c8;   g_q <= 8'd0; b_q <= s8;   end
      endcase
    end
  end

  assign out_valid_o = v_q[5];
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;

endmodule

/* hdl/aurora_pixel_color_generator.sv */
// Plasma-effect pixel colour generator.
// Input stream: one beat per LED, carrying its index along the strip and the
// frame time in 1/1024 s. Output stream: one beat per input beat, in order,
// carrying the 8-bit red, green and blue of that LED.
// Configuration: a write channel (cfg_valid_i/cfg_ready_o) selecting a
// register by cfg_index_i: 0 strip length, 1 drift speed, 2 hue band low,
// 3 hue band high. Other indexes are dropped. Write only while idle.
// Throughput: one beat per cycle, sustained while m_axis_tready stays high.
// A beat passes the pixel-position divider, which resolves INDEX_BITS + 16
// quotient bits, one per stage; then the phase multipliers, the queue, and
// the sine ROM and colour conversion.
// A four-entry queue splits the phase front end from the colour back end.
// When the receiver stalls, the back end holds; the front end keeps taking
// beats until the queue fills, then drops s_axis_tready.
// Reset clears all valid state and loads the register defaults
// (strip length 60, drift 1.0, hue band 0.3 to 0.85 of a turn).
module aurora_pixel_color_generator #(
  parameter int unsigned SINE_TABLE_BITS = apcg_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned INDEX_BITS      = apcg_pkg::INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] pixel_index, [43:12] frame_time, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [apcg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [apcg_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [apcg_pkg::LEN_W-1:0] strip_length_q;
  logic [15:0]                drift_speed_q, hue_low_q, hue_high_q;
  logic [apcg_pkg::LEN_W-1:0] divisor;

  // Registers are always ready to take a beat
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_length_q <= apcg_pkg::STRIP_LENGTH_RST;
      drift_speed_q  <= apcg_pkg::DRIFT_SPEED_RST;
      hue_low_q      <= apcg_pkg::HUE_LOW_RST;
      hue_high_q     <= apcg_pkg::HUE_HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        apcg_pkg::REG_STRIP_LENGTH: strip_length_q <= cfg_data_i[apcg_pkg::LEN_W-1:0];
        apcg_pkg::REG_DRIFT_SPEED:  drift_speed_q  <= cfg_data_i;
        apcg_pkg::REG_HUE_LOW:      hue_low_q      <= cfg_data_i;
        apcg_pkg::REG_HUE_HIGH:     hue_high_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero strip length divides as one
  assign divisor = (strip_length_q == '0) ? apcg_pkg::LEN_W'(1) : strip_length_q;

  logic             front_en, front_valid;
  apcg_pkg::phase_t front_phase, queue_phase;
  logic             q_full, q_empty, q_pop;

  // Advance the front end only while the queue has room
  assign front_en      = !q_full;
  assign s_axis_tready = front_en;

  apcg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (front_en),
    .in_valid_i    (s_axis_tvalid),
    .pixel_index_i (INDEX_BITS'(s_axis_tdata[11:0])),
    .frame_time_i  (s_axis_tdata[43:12]),
    .divisor_i     (divisor),
    .drift_speed_i (drift_speed_q),
    .out_valid_o   (front_valid),
    .phase_o       (front_phase)
  );

  apcg_fifo #(
    .WIDTH ($bits(apcg_pkg::phase_t)),
    .DEPTH (apcg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid && front_en),
    .data_i  (front_phase),
    .pop_i   (q_pop),
    .data_o  (queue_phase),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  apcg_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_avail_i  (!q_empty),
    .phase_i     (queue_phase),
    .pop_o       (q_pop),
    .hue_low_i   (hue_low_q),
    .hue_high_i  (hue_high_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .red_o       (m_axis_tdata[7:0]),
    .green_o     (m_axis_tdata[15:8]),
    .blue_o      (m_axis_tdata[23:16])
  );

endmodule

/* hdl/apcg_checker.sv */
module apcg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        cfg_ready_o
);

  // Output register is cleared while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output beat during reset");

  // A stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // Full saturation leaves one channel dark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0 ||
                       m_axis_tdata[23:16] == 8'd0))
    else $error("no dark channel in output colour");

  // Register writes never back-pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration channel stalled");

endmodule

bind aurora_pixel_color_generator apcg_checker u_apcg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
